[hw/rtl/tcb_pkg.sv]
// Shared constants, row operation codes and control struct for the transitive closure block.
package tcb_pkg;

  localparam int MAX_NODES = 64;
  localparam int ROW_IDX_W = $clog2(MAX_NODES);
  localparam int ROW_W     = 64;
  localparam int NODE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int IN_DAT_W  = 16;
  localparam int OUT_DAT_W = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_LOOPS = 2'd1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ROW_OP_EDGE,
    ROW_OP_PREP,
    ROW_OP_CLOSE
  } row_op_e;

  typedef struct packed {
    row_op_e             op;
    logic [NODE_W-1:0]   sel_bit;
    logic                self_loops;
    logic                row_valid;
  } row_ctrl_t;

endpackage

[hw/rtl/transitive_closure_bitmatrix.sv]
// An edge passes through accept, row read and row write; a plain item without last is only accepted.
// Closure after the last item: trim every row, run Warshall over each pivot and row, then read each row out.
// Each row step uses the single row RAM port pair for one row read followed by one row write.
// The input is not ready while an edge or a closure is in progress.
// Reset clears the per-row valid bits (so the matrix reads as zero) and the registers to defaults.
// The RAM itself is not cleared; a row without its valid bit reads as all zero.
module transitive_closure_bitmatrix (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tcb_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  // Input stream of edges.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tcb_pkg::IN_DAT_W-1:0]        s_axis_tdata,  // src_node[5:0], dst_node[11:6]
  input  logic                                s_axis_tuser,  // has_edge
  input  logic                                s_axis_tlast,  // last
  // Output stream of reachability rows.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tcb_pkg::OUT_DAT_W-1:0]       m_axis_tdata,  // row_index[5:0], reach_row[69:6]
  output logic                                m_axis_tlast   // last_row
);
  import tcb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_PREP_RD,
    ST_PREP_WR,
    ST_PIV_RD,
    ST_PIV_LD,
    ST_CL_RD,
    ST_CL_WR,
    ST_OUT_RD,
    ST_OUT_WR
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       node_count_q;
  logic                   self_loops_q;
  logic [MAX_NODES-1:0]   valid_q;
  logic [NODE_W-1:0]      src_q;
  logic [NODE_W-1:0]      dst_q;
  logic                   last_q;
  logic [ROW_IDX_W-1:0]   j_q;
  logic [ROW_IDX_W-1:0]   k_q;
  logic [ROW_W-1:0]       pivot_q;
  logic                   out_valid_q;
  logic [NODE_W-1:0]      out_index_q;
  logic [ROW_W-1:0]       out_row_q;
  logic                   out_last_q;

  logic [CNT_W-1:0]       n_eff;
  logic [ROW_IDX_W-1:0]   n_last;
  logic [ROW_W-1:0]       col_mask;
  logic [ROW_IDX_W-1:0]   cur_addr;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       new_row;
  logic                   unit_wr;
  logic                   ram_we;
  row_ctrl_t              ctrl;
  logic                   in_fire;
  logic                   edge_ok;
  logic                   out_free;

  // The node count in use is clamped to the range one to MAX_NODES.
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
    n_last = ROW_IDX_W'(n_eff - CNT_W'(1));
    for (int c = 0; c < ROW_W; c++) begin
      col_mask[c] = (CNT_W'(c) < n_eff);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign edge_ok       = s_axis_tuser
                         & ({1'b0, s_axis_tdata[NODE_W-1:0]} < n_eff)
                         & ({1'b0, s_axis_tdata[2*NODE_W-1:NODE_W]} < n_eff);
  assign out_free      = ~out_valid_q | m_axis_tready;

  // The row address is the same in a read state and in the write state that follows it,
  // so the RAM data and the valid bit always refer to the same row.
  always_comb begin
    case (state_q)
      ST_EDGE_RD, ST_EDGE_WR: cur_addr = src_q[ROW_IDX_W-1:0];
      ST_PIV_RD, ST_PIV_LD:   cur_addr = k_q;
      default:                cur_addr = j_q;
    endcase
  end

  always_comb begin
    ctrl.self_loops = self_loops_q;
    ctrl.row_valid  = valid_q[cur_addr];
    case (state_q)
      ST_EDGE_RD, ST_EDGE_WR: begin
        ctrl.op      = ROW_OP_EDGE;
        ctrl.sel_bit = dst_q;
      end
      ST_PREP_RD, ST_PREP_WR: begin
        ctrl.op      = ROW_OP_PREP;
        ctrl.sel_bit = NODE_W'(j_q);
      end
      default: begin
        ctrl.op      = ROW_OP_CLOSE;
        ctrl.sel_bit = NODE_W'(k_q);
      end
    endcase
  end

  tcb_row_unit u_row_unit (
    .ctrl_i      (ctrl),
    .rd_row_i    (rd_row),
    .pivot_row_i (pivot_q),
    .col_mask_i  (col_mask),
    .row_o       (new_row),
    .wr_o        (unit_wr)
  );

  assign ram_we = unit_wr & ((state_q == ST_EDGE_WR) | (state_q == ST_PREP_WR)
                             | (state_q == ST_CL_WR));

  tcb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_addr),
    .wdata_i (new_row),
    .raddr_i (cur_addr),
    .rdata_o (rd_row)
  );

  // Sequencer: edge insert, row trim pass, Warshall over pivots k and rows j, then row output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NODE_COUNT_RST;
      self_loops_q <= 1'b0;
      valid_q      <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      j_q          <= '0;
      k_q          <= '0;
      pivot_q      <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_index_q  <= '0;
      out_row_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NODE_COUNT: node_count_q <= cfg_data_i;
          CFG_SELF_LOOPS: self_loops_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // A new row loads the output register in the same cycle the previous one leaves.
      if ((state_q == ST_OUT_WR) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (ram_we) begin
        valid_q[cur_addr] <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            src_q  <= s_axis_tdata[NODE_W-1:0];
            dst_q  <= s_axis_tdata[2*NODE_W-1:NODE_W];
            last_q <= s_axis_tlast;
            j_q    <= '0;
            if (edge_ok) begin
              state_q <= ST_EDGE_RD;
            end else if (s_axis_tlast) begin
              state_q <= ST_PREP_RD;
            end
          end
        end
        ST_EDGE_RD: state_q <= ST_EDGE_WR;
        ST_EDGE_WR: state_q <= last_q ? ST_PREP_RD : ST_IDLE;
        ST_PREP_RD: state_q <= ST_PREP_WR;
        ST_PREP_WR: begin
          if (j_q == n_last) begin
            k_q     <= '0;
            state_q <= ST_PIV_RD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_PREP_RD;
          end
        end
        ST_PIV_RD: state_q <= ST_PIV_LD;
        ST_PIV_LD: begin
          pivot_q <= rd_row;
          j_q     <= '0;
          state_q <= ST_CL_RD;
        end
        ST_CL_RD: state_q <= ST_CL_WR;
        ST_CL_WR: begin
          if (j_q == n_last) begin
            j_q <= '0;
            if (k_q == n_last) begin
              state_q <= ST_OUT_RD;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_PIV_RD;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_CL_RD;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_WR;
        ST_OUT_WR: begin
          // The read address stays on row j, so the RAM data holds while the output stalls.
          if (out_free) begin
            out_index_q <= NODE_W'(j_q);
            out_row_q   <= rd_row;
            out_last_q  <= (j_q == n_last);
            if (j_q == n_last) begin
              valid_q <= '0;
              state_q <= ST_IDLE;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_row_q, out_index_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[hw/rtl/tcb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module tcb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/tcb_row_unit.sv]
// Shared row unit: edge insert, row trim with optional diagonal set, and the Warshall row merge.
module tcb_row_unit (
  input  tcb_pkg::row_ctrl_t          ctrl_i,
  input  logic [tcb_pkg::ROW_W-1:0]   rd_row_i,
  input  logic [tcb_pkg::ROW_W-1:0]   pivot_row_i,
  input  logic [tcb_pkg::ROW_W-1:0]   col_mask_i,
  output logic [tcb_pkg::ROW_W-1:0]   row_o,
  output logic                        wr_o
);
  import tcb_pkg::*;

  logic [ROW_W-1:0] base;
  logic [ROW_W-1:0] onehot;

  always_comb begin
    // A row that was never written since the last clear reads as zero.
    base   = ctrl_i.row_valid ? rd_row_i : '0;
    onehot = ROW_W'(1) << ctrl_i.sel_bit;
    row_o  = base;
    wr_o   = 1'b0;
    case (ctrl_i.op)
      ROW_OP_EDGE: begin
        row_o = base | onehot;
        wr_o  = 1'b1;
      end
      ROW_OP_PREP: begin
        row_o = (base & col_mask_i) | (ctrl_i.self_loops ? onehot : '0);
        wr_o  = 1'b1;
      end
      ROW_OP_CLOSE: begin
        row_o = base | pivot_row_i;
        wr_o  = base[ctrl_i.sel_bit];
      end
      default: begin
        row_o = base;
        wr_o  = 1'b0;
      end
    endcase
  end

endmodule
